// ===== rtl/rtppk_pkg.sv =====
// rtppk_pkg: shared types and constants for the RTP/TS datagram packetizer.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package rtppk_pkg;

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] RTP_PAYLOAD_MP2T = 8'd33;
    localparam int         RTP_HEADER_BYTES = 12;
    localparam int         HDR_IDX_W        = 4;
    localparam int         HDR_BITS         = RTP_HEADER_BYTES * 8;
    localparam int         TS_SIZE          = 188;

    localparam int         QUEUE_DEPTH      = 4;
    localparam int         QUEUE_PTR_W      = 2;

    // Register index as decoded from the word address bit of paddr
    localparam logic       REG_IDX_ENABLE   = 1'b0;
    localparam logic       REG_IDX_SSRC     = 1'b1;

    // One classified input item, handed from the front to the back
    typedef struct packed {
        logic [7:0]  ts_byte;
        logic        datagram_last;
        logic        with_header;
        logic [15:0] seq;
        logic [31:0] stamp;
        logic [31:0] ssrc;
    } rtppk_desc_t;

endpackage

// ===== rtl/rtppk_front.sv =====
// rtppk_front: accepts TS bytes, tracks datagram fill and RTP sequence,
// and classifies each item (header needed, datagram end). Uses rtppk_pkg.
`timescale 1ns / 1ps

module rtppk_front #(
    parameter int DATAGRAM_LIMIT = 1460
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            ts_byte,
    input  logic                  packet_last,
    input  logic [31:0]           time_ms,
    input  logic                  rtp_enable,
    input  logic [31:0]           rtp_ssrc,
    output rtppk_pkg::rtppk_desc_t desc
);

    localparam int FILL_W = $clog2(DATAGRAM_LIMIT + 1);
    localparam logic [FILL_W-1:0] CLOSE_ABOVE  = FILL_W'(DATAGRAM_LIMIT - rtppk_pkg::TS_SIZE);
    localparam logic [FILL_W-1:0] LIMIT_V      = FILL_W'(DATAGRAM_LIMIT);
    localparam logic [FILL_W-1:0] HDR_PLUS_ONE = FILL_W'(rtppk_pkg::RTP_HEADER_BYTES + 1);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [15:0]       seq_reg;
    logic [15:0]       seq_next;
    logic [FILL_W-1:0] fill_sum;
    logic              with_header;
    logic              last;

    always_comb
    begin
        with_header = rtp_enable && (fill_reg == '0);
        // fill never exceeds the limit, so the sum fits
        fill_sum    = fill_reg + (with_header ? HDR_PLUS_ONE : FILL_W'(1));
        last        = (packet_last && (fill_sum > CLOSE_ABOVE)) || (fill_sum >= LIMIT_V);

        fill_next = fill_reg;
        seq_next  = seq_reg;
        if (accept)
        begin
            fill_next = last ? '0 : fill_sum;
            if (with_header)
            begin
                seq_next = seq_reg + 16'd1;
            end
        end

        desc.ts_byte       = ts_byte;
        desc.datagram_last = last;
        desc.with_header   = with_header;
        desc.seq           = seq_reg;
        desc.stamp         = time_ms;
        desc.ssrc          = rtp_ssrc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            seq_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            seq_reg  <= seq_next;
        end
    end

endmodule

// ===== rtl/rtppk_queue.sv =====
// rtppk_queue: short descriptor queue between front and back.
// Uses rtppk_pkg for the descriptor type and depth.
`timescale 1ns / 1ps

module rtppk_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  rtppk_pkg::rtppk_desc_t wr_data,
    output logic                   full,
    input  logic                   rd_en,
    output rtppk_pkg::rtppk_desc_t rd_data,
    output logic                   empty
);

    rtppk_pkg::rtppk_desc_t mem [rtppk_pkg::QUEUE_DEPTH];

    logic [rtppk_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [rtppk_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [rtppk_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [rtppk_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [rtppk_pkg::QUEUE_PTR_W:0]   count_reg;
    logic [rtppk_pkg::QUEUE_PTR_W:0]   count_next;

    always_comb
    begin
        full    = (count_reg == (rtppk_pkg::QUEUE_PTR_W + 1)'(rtppk_pkg::QUEUE_DEPTH));
        empty   = (count_reg == '0);
        rd_data = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg + (wr_en ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (rd_en ? 1'b1 : 1'b0);
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/rtppk_back.sv =====
// rtppk_back: expands descriptors into output bytes (12 RTP header bytes
// where flagged, then the payload byte) into an output register. Uses rtppk_pkg.
`timescale 1ns / 1ps

module rtppk_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rtppk_pkg::rtppk_desc_t head,
    input  logic                   head_empty,
    output logic                   head_pop,
    input  logic                   pop,
    output logic                   empty,
    output logic [7:0]             out_byte,
    output logic                   datagram_last
);

    logic [rtppk_pkg::HDR_IDX_W-1:0] hdr_idx_reg;
    logic [rtppk_pkg::HDR_IDX_W-1:0] hdr_idx_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [7:0]                      out_byte_reg;
    logic [7:0]                      out_byte_next;
    logic                            out_last_reg;
    logic                            out_last_next;
    logic [rtppk_pkg::HDR_BITS-1:0]  hdr_word;
    logic [rtppk_pkg::HDR_BITS-1:0]  hdr_shift;
    logic                            advance;
    logic                            in_header;

    always_comb
    begin
        hdr_word  = {rtppk_pkg::RTP_VERSION_BYTE, rtppk_pkg::RTP_PAYLOAD_MP2T,
                     head.seq, head.stamp, head.ssrc};
        hdr_shift = hdr_word << {hdr_idx_reg, 3'b000};
        in_header = head.with_header &&
                    (hdr_idx_reg < rtppk_pkg::HDR_IDX_W'(rtppk_pkg::RTP_HEADER_BYTES));
        // load the output register when it is free or being taken
        advance   = !head_empty && (!out_valid_reg || pop);

        head_pop       = 1'b0;
        hdr_idx_next   = hdr_idx_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !pop;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (in_header)
            begin
                out_byte_next = hdr_shift[rtppk_pkg::HDR_BITS-1 -: 8];
                out_last_next = 1'b0;
                hdr_idx_next  = hdr_idx_reg + 1'b1;
            end
            else
            begin
                out_byte_next = head.ts_byte;
                out_last_next = head.datagram_last;
                hdr_idx_next  = '0;
                head_pop      = 1'b1;
            end
        end

        empty         = !out_valid_reg;
        out_byte      = out_byte_reg;
        datagram_last = out_last_reg;
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hdr_idx_reg   <= hdr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/rtp_ts_datagram_packetizer.sv =====
// rtp_ts_datagram_packetizer: top level with APB config registers, front,
// descriptor queue and back. Depends on rtppk_pkg, rtppk_front, rtppk_queue, rtppk_back.
`timescale 1ns / 1ps

// Packs TS bytes into datagrams, optionally opening each with a 12-byte RTP
// header (sequence number, time_ms stamp, SSRC). Payload bytes flow at one
// item per cycle while pop is held; the byte that opens a datagram with RTP
// on becomes 13 output bytes in the back end, the header and then the payload,
// since the output register emits one byte per cycle. A four-entry descriptor
// queue between front and back absorbs that burst, so input stalls only when
// the queue fills. An accepted byte passes through the queue, then the output register.
// Registers: 0x0 rtp_enable (bit 0), 0x4 rtp_ssrc; both reset to zero.
module rtp_ts_datagram_packetizer #(
    parameter int DATAGRAM_LIMIT = 1460
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  ts_byte,
    input  logic        packet_last,
    input  logic [31:0] time_ms,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        datagram_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                   rtp_enable_reg;
    logic                   rtp_enable_next;
    logic [31:0]            rtp_ssrc_reg;
    logic [31:0]            rtp_ssrc_next;
    logic                   cfg_write;
    logic                   in_accept;
    logic                   head_empty;
    logic                   head_pop;
    rtppk_pkg::rtppk_desc_t front_desc;
    rtppk_pkg::rtppk_desc_t head_desc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_accept = push && !full;

    always_comb
    begin
        rtp_enable_next = rtp_enable_reg;
        rtp_ssrc_next   = rtp_ssrc_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                rtppk_pkg::REG_IDX_ENABLE: rtp_enable_next = pwdata[0];
                rtppk_pkg::REG_IDX_SSRC:   rtp_ssrc_next   = pwdata;
                default:                   rtp_ssrc_next   = rtp_ssrc_reg;
            endcase
        end

        unique case (paddr[2])
            rtppk_pkg::REG_IDX_ENABLE: prdata = {31'd0, rtp_enable_reg};
            rtppk_pkg::REG_IDX_SSRC:   prdata = rtp_ssrc_reg;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rtp_enable_reg <= 1'b0;
            rtp_ssrc_reg   <= '0;
        end
        else
        begin
            rtp_enable_reg <= rtp_enable_next;
            rtp_ssrc_reg   <= rtp_ssrc_next;
        end
    end

    rtppk_front #(
        .DATAGRAM_LIMIT (DATAGRAM_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .ts_byte     (ts_byte),
        .packet_last (packet_last),
        .time_ms     (time_ms),
        .rtp_enable  (rtp_enable_reg),
        .rtp_ssrc    (rtp_ssrc_reg),
        .desc        (front_desc)
    );

    rtppk_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept),
        .wr_data (front_desc),
        .full    (full),
        .rd_en   (head_pop),
        .rd_data (head_desc),
        .empty   (head_empty)
    );

    rtppk_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head_desc),
        .head_empty    (head_empty),
        .head_pop      (head_pop),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .datagram_last (datagram_last)
    );

endmodule
